// ===== hw/rtl/crcf_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the escaped frame transmitter.
package crcf_pkg;

   localparam int ByteW   = 8;
   localparam int CrcW    = 16;
   localparam int MaxOut  = 8;
   localparam int IdxW    = 3;
   localparam int PosW    = 4;

   localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;
   localparam logic [CrcW-1:0] CrcPoly = 16'h1021;

   localparam logic [ByteW-1:0] ResetEndCode   = 8'd192;
   localparam logic [ByteW-1:0] ResetEscCode   = 8'd219;
   localparam logic [ByteW-1:0] ResetEscEnd    = 8'd220;
   localparam logic [ByteW-1:0] ResetEscEsc    = 8'd221;

   typedef struct packed {
      logic [ByteW-1:0] end_code;
      logic [ByteW-1:0] escape_code;
      logic [ByteW-1:0] escaped_end_code;
      logic [ByteW-1:0] escaped_escape_code;
   } codes_type;

   // Full line sequence caused by one input transaction.
   typedef struct packed {
      logic [MaxOut-1:0][ByteW-1:0] line_bytes;
      logic [MaxOut-1:0]            closed;
      logic [IdxW-1:0]              last_idx;
      logic [CrcW-1:0]              crc;
   } expand_type;

   typedef struct packed {
      logic [ByteW-1:0] first;
      logic [ByteW-1:0] second;
      logic             two;
   } stuffed_type;

   // MSB-first CRC-16, one byte.
   function automatic logic [CrcW-1:0] crc_feed(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
      logic [CrcW-1:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < ByteW; i++) begin
         if (c[CrcW-1]) begin
            c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[CrcW-2:0], 1'b0};
         end
      end
      return c;
   endfunction

   // A byte equal to the delimiter is escaped as a delimiter even if it
   // also equals the escape prefix.
   function automatic stuffed_type stuff(input codes_type codes, input logic [ByteW-1:0] b);
      stuffed_type s;
      s.first  = b;
      s.second = codes.escaped_escape_code;
      s.two    = 1'b0;
      if (b == codes.end_code) begin
         s.first  = codes.escape_code;
         s.second = codes.escaped_end_code;
         s.two    = 1'b1;
      end else if (b == codes.escape_code) begin
         s.first  = codes.escape_code;
         s.second = codes.escaped_escape_code;
         s.two    = 1'b1;
      end
      return s;
   endfunction

endpackage

// ===== hw/rtl/crcf_expander.sv =====
// Expands one payload byte into its stuffed line sequence and next CRC.
module crcf_expander import crcf_pkg::*; (
   input  codes_type        codes,
   input  logic [ByteW-1:0] payload_byte,
   input  logic             is_last,
   input  logic             inside_frame,
   input  logic [CrcW-1:0]  running_crc,
   output expand_type       result
);

   always_comb begin
      logic [PosW-1:0]  pos;
      logic [PosW-1:0]  last_pos;
      logic [CrcW-1:0]  crc_next;
      logic [ByteW-1:0] src [3];
      stuffed_type      s;

      result   = '0;
      pos      = '0;
      crc_next = crc_feed(running_crc, payload_byte);
      src[0]   = payload_byte;
      src[1]   = crc_next[7:0];
      src[2]   = crc_next[15:8];

      if (!inside_frame) begin
         result.line_bytes[pos[IdxW-1:0]] = codes.end_code;
         pos = pos + 4'd1;
      end

      // data byte, then CRC low and high on the closing transaction
      for (int k = 0; k < 3; k++) begin
         if (k == 0 || is_last) begin
            s = stuff(codes, src[k]);
            result.line_bytes[pos[IdxW-1:0]] = s.first;
            pos = pos + 4'd1;
            if (s.two) begin
               result.line_bytes[pos[IdxW-1:0]] = s.second;
               pos = pos + 4'd1;
            end
         end
      end

      if (is_last) begin
         result.line_bytes[pos[IdxW-1:0]] = codes.end_code;
         result.closed[pos[IdxW-1:0]]     = 1'b1;
         pos = pos + 4'd1;
      end

      last_pos        = pos - 4'd1;
      result.last_idx = last_pos[IdxW-1:0];
      result.crc      = is_last ? CrcInit : crc_next;
   end

endmodule

// ===== hw/rtl/crc16_escaped_frame_transmitter.sv =====
// Top level: byte-stuffed frame transmitter with appended CRC-16.
//
// req_* carries raw payload bytes; req_tlast marks the final byte of a frame.
// rsp_* carries the line stream one byte per transaction: an opening
// delimiter before the first byte of a frame, escaped data, the CRC-16
// (0x1021, init 0xFFFF) low byte first and escaped, then the closing
// delimiter, flagged by rsp_tuser. rsp_tlast marks the last line byte caused
// by one input transaction.
// An input transaction is expanded in the cycle it is accepted into an
// output buffer; its first line byte is valid the next cycle. It then sends one
// line byte per cycle while rsp_tready is high: 1 or 2 for a mid-frame byte, up
// to 8 for a single-byte frame. The output buffer is the only limit: the next
// input is taken in the same cycle the previous one's last line byte is taken.
// When rsp_tready is low the current byte holds and req_tready drops once
// the buffer is occupied.
// Reset clears the buffer, closes any open frame, sets the CRC to 0xFFFF and
// loads the default codes (192, 219, 220, 221). The csr_* port holds the four
// code registers at byte addresses 0, 4, 8 and 12; write them while idle.
module crc16_escaped_frame_transmitter import crcf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // payload_byte
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   // line_byte
   output logic [7:0]  rsp_tdata,
   // frame_closed
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [1:0] {
      REG_END_CODE = 2'd0,
      REG_ESCAPE_CODE = 2'd1,
      REG_ESCAPED_END = 2'd2,
      REG_ESCAPED_ESC = 2'd3
   } reg_index_type;

   codes_type               codes_ff, codes_in;
   logic [CrcW-1:0]         crc_ff, crc_in;
   logic                    inside_ff, inside_in;
   logic                    buf_valid_ff, buf_valid_in;
   logic [IdxW-1:0]         idx_ff, idx_in;
   expand_type              buf_ff, buf_in;
   expand_type              expanded;
   reg_index_type           csr_index;
   logic                    csr_write;
   logic                    req_fire;
   logic                    rsp_fire;
   logic                    at_last;

   crcf_expander u_expander (
      .codes        (codes_ff),
      .payload_byte (req_tdata),
      .is_last      (req_tlast),
      .inside_frame (inside_ff),
      .running_crc  (crc_ff),
      .result       (expanded)
   );

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_index)
         REG_END_CODE:    csr_prdata[7:0] = codes_ff.end_code;
         REG_ESCAPE_CODE: csr_prdata[7:0] = codes_ff.escape_code;
         REG_ESCAPED_END: csr_prdata[7:0] = codes_ff.escaped_end_code;
         REG_ESCAPED_ESC: csr_prdata[7:0] = codes_ff.escaped_escape_code;
         default:         csr_prdata = '0;
      endcase
   end

   assign at_last    = (idx_ff == buf_ff.last_idx);
   assign rsp_tvalid = buf_valid_ff;
   assign rsp_tdata  = buf_ff.line_bytes[idx_ff];
   assign rsp_tuser  = buf_ff.closed[idx_ff];
   assign rsp_tlast  = at_last;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = !buf_valid_ff || (rsp_fire && at_last);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      codes_in     = codes_ff;
      crc_in       = crc_ff;
      inside_in    = inside_ff;
      buf_valid_in = buf_valid_ff;
      idx_in       = idx_ff;
      buf_in       = buf_ff;

      if (csr_write) begin
         unique case (csr_index)
            REG_END_CODE:    codes_in.end_code            = csr_pwdata[7:0];
            REG_ESCAPE_CODE: codes_in.escape_code         = csr_pwdata[7:0];
            REG_ESCAPED_END: codes_in.escaped_end_code    = csr_pwdata[7:0];
            REG_ESCAPED_ESC: codes_in.escaped_escape_code = csr_pwdata[7:0];
            default:         codes_in = codes_ff;
         endcase
      end

      if (req_fire) begin
         buf_in       = expanded;
         idx_in       = '0;
         buf_valid_in = 1'b1;
         crc_in       = expanded.crc;
         inside_in    = !req_tlast;
      end else if (rsp_fire) begin
         if (at_last) begin
            buf_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         codes_ff.end_code            <= ResetEndCode;
         codes_ff.escape_code         <= ResetEscCode;
         codes_ff.escaped_end_code    <= ResetEscEnd;
         codes_ff.escaped_escape_code <= ResetEscEsc;
         crc_ff       <= CrcInit;
         inside_ff    <= 1'b0;
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         codes_ff     <= codes_in;
         crc_ff       <= crc_in;
         inside_ff    <= inside_in;
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
      end
   end

endmodule
